// ----- sv/seven_segment_number_shifter_core_macros.svh -----
// Assertion macros shared by the checker of the number shifter core
`ifndef SEVEN_SEGMENT_NUMBER_SHIFTER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_SHIFTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SSNS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssns check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SSNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssns check failed");

`endif

// ----- sv/ssns_pkg.sv -----
// Types, codes and the digit font of the number shifter core
package ssns_pkg;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_E     = 8'h9E;
    localparam logic [7:0] SEG_DASH  = 8'h02;

    localparam logic REQ_DISPLAY = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OFFSET    = 2'd1,
        STATUS_FIELD_END = 2'd2
    } status_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_BLANK = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_FIN   = 8'b0000_1000,
        ST_EFILL = 8'b0001_0000,
        ST_CLR   = 8'b0010_0000,
        ST_SHIFT = 8'b0100_0000,
        ST_REJ   = 8'b1000_0000
    } state_t;

    function automatic logic [7:0] digit_font(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0:    seg = 8'hfc;
            4'd1:    seg = 8'h60;
            4'd2:    seg = 8'hda;
            4'd3:    seg = 8'hf2;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'hb6;
            4'd6:    seg = 8'hbe;
            4'd7:    seg = 8'he0;
            4'd8:    seg = 8'hfe;
            4'd9:    seg = 8'hf6;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ----- sv/seven_segment_number_shifter_core.sv -----
// Top level of the seven-segment number shifter core
// One item at a time. A display item blanks its field one digit a cycle, then
// runs one divide-by-ten step per cycle on the reciprocal unit (up to
// five digits), writes the dash or an E fill one digit a cycle, and shifts out
// min(active_digits, STORE_DIGITS, 8) bytes at one bit per cycle unless the
// output stalls. A clear item blanks the first min(active_digits,
// STORE_DIGITS, 8) digits and then shifts them out. A rejected item gives
// one result. in_stall stays high from acceptance until the last result is
// loaded into the output register, and a stall on the output keeps it high.
module seven_segment_number_shifter_core #(
    parameter int STORE_DIGITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [7:0]         field_offset,
    input  logic [7:0]         field_length,
    input  logic signed [15:0] number_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               bit_valid,
    output logic               data_pin,
    output logic               latch_pulse,
    output logic               last
);

    localparam int AW  = (STORE_DIGITS > 1) ? $clog2(STORE_DIGITS) : 1;
    localparam int WW  = $clog2(STORE_DIGITS + 1);
    localparam int CAP = (STORE_DIGITS < 8) ? STORE_DIGITS : 8;

    ssns_pkg::state_t state_reg, state_next;

    logic [3:0]    active_reg;
    logic [7:0]    store_reg [STORE_DIGITS];
    logic [WW-1:0] ptr_reg, ptr_next;
    logic [WW-1:0] off_reg, off_next;
    logic [WW-1:0] wend_reg, wend_next;
    logic [15:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [1:0]    rej_reg, rej_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic          bit_valid_reg, bit_valid_next;
    logic          data_pin_reg, data_pin_next;
    logic          latch_reg, latch_next;
    logic          last_reg, last_next;

    logic          store_we;
    logic [AW-1:0] store_waddr;
    logic [7:0]    store_wdata;

    logic          in_accept;
    logic          out_load;
    logic [3:0]    shift_n;
    logic [5:0]    last_idx;
    logic [8:0]    field_end;
    logic [15:0]   in_mag;
    logic [15:0]   div_q;
    logic [3:0]    div_r;
    logic [7:0]    shift_byte;

    ssns_div10 u_div10 (
        .dividend  (mag_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign in_stall   = (state_reg != ssns_pkg::ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_load   = !out_valid_reg || !out_stall;
    assign shift_n    = (active_reg > 4'(CAP)) ? 4'(CAP) : active_reg;
    assign last_idx   = 6'({shift_n, 3'b000} - 7'd1);
    assign field_end  = 9'(field_offset) + 9'(field_length);
    assign in_mag     = number_value[15] ? 16'(~number_value + 16'sd1) : 16'(number_value);
    assign shift_byte = store_reg[AW'(cnt_reg[5:3])];

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        off_next       = off_reg;
        wend_next      = wend_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        bit_valid_next = bit_valid_reg;
        data_pin_next  = data_pin_reg;
        latch_next     = latch_reg;
        last_next      = last_reg;
        store_we       = 1'b0;
        store_waddr    = AW'(ptr_reg);
        store_wdata    = ssns_pkg::SEG_BLANK;

        case (state_reg)
            ssns_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    cnt_next = '0;
                    if (req_type == ssns_pkg::REQ_CLEAR)
                    begin
                        ptr_next   = '0;
                        state_next = ssns_pkg::ST_CLR;
                    end
                    else if (9'(field_offset) > 9'(STORE_DIGITS))
                    begin
                        rej_next   = ssns_pkg::STATUS_OFFSET;
                        state_next = ssns_pkg::ST_REJ;
                    end
                    else if (field_end > 9'(STORE_DIGITS))
                    begin
                        rej_next   = ssns_pkg::STATUS_FIELD_END;
                        state_next = ssns_pkg::ST_REJ;
                    end
                    else
                    begin
                        off_next   = WW'(field_offset);
                        ptr_next   = WW'(field_offset);
                        wend_next  = WW'(field_end);
                        mag_next   = in_mag;
                        neg_next   = number_value[15];
                        state_next = ssns_pkg::ST_BLANK;
                    end
                end
            end

            ssns_pkg::ST_BLANK:
            begin
                if (ptr_reg == wend_reg)
                begin
                    ptr_next   = off_reg;
                    state_next = ssns_pkg::ST_DIV;
                end
                else
                begin
                    store_we = 1'b1;
                    ptr_next = ptr_reg + WW'(1);
                end
            end

            ssns_pkg::ST_DIV:
            begin
                if (mag_reg == '0)
                begin
                    state_next = ssns_pkg::ST_FIN;
                end
                else if (ptr_reg >= wend_reg)
                begin
                    // digits overflow the field
                    ptr_next   = off_reg;
                    state_next = ssns_pkg::ST_EFILL;
                end
                else
                begin
                    store_we    = 1'b1;
                    store_wdata = ssns_pkg::digit_font(div_r);
                    ptr_next    = ptr_reg + WW'(1);
                    mag_next    = div_q;
                end
            end

            ssns_pkg::ST_FIN:
            begin
                if (neg_reg && (ptr_reg >= wend_reg))
                begin
                    ptr_next   = off_reg;
                    state_next = ssns_pkg::ST_EFILL;
                end
                else
                begin
                    if (neg_reg)
                    begin
                        store_we    = 1'b1;
                        store_wdata = ssns_pkg::SEG_DASH;
                    end
                    state_next = ssns_pkg::ST_SHIFT;
                end
            end

            ssns_pkg::ST_EFILL:
            begin
                if (ptr_reg == wend_reg)
                begin
                    state_next = ssns_pkg::ST_SHIFT;
                end
                else
                begin
                    store_we    = 1'b1;
                    store_wdata = ssns_pkg::SEG_E;
                    ptr_next    = ptr_reg + WW'(1);
                end
            end

            ssns_pkg::ST_CLR:
            begin
                if (ptr_reg == WW'(shift_n))
                begin
                    state_next = ssns_pkg::ST_SHIFT;
                end
                else
                begin
                    store_we = 1'b1;
                    ptr_next = ptr_reg + WW'(1);
                end
            end

            ssns_pkg::ST_SHIFT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ssns_pkg::STATUS_OK;
                    if (shift_n == '0)
                    begin
                        // bare latch pulse
                        bit_valid_next = 1'b0;
                        data_pin_next  = 1'b0;
                        latch_next     = 1'b1;
                        last_next      = 1'b1;
                        state_next     = ssns_pkg::ST_IDLE;
                    end
                    else
                    begin
                        bit_valid_next = 1'b1;
                        data_pin_next  = ~shift_byte[cnt_reg[2:0]];
                        latch_next     = (cnt_reg == last_idx);
                        last_next      = (cnt_reg == last_idx);
                        cnt_next       = cnt_reg + 6'd1;
                        if (cnt_reg == last_idx)
                        begin
                            state_next = ssns_pkg::ST_IDLE;
                        end
                    end
                end
            end

            ssns_pkg::ST_REJ:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rej_reg;
                    bit_valid_next = 1'b0;
                    data_pin_next  = 1'b0;
                    latch_next     = 1'b0;
                    last_next      = 1'b1;
                    state_next     = ssns_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ssns_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssns_pkg::ST_IDLE;
            active_reg    <= 4'd8;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STORE_DIGITS; i++)
            begin
                store_reg[i] <= ssns_pkg::SEG_BLANK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (store_we)
            begin
                store_reg[store_waddr] <= store_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        off_reg       <= off_next;
        wend_reg      <= wend_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        rej_reg       <= rej_next;
        status_reg    <= status_next;
        bit_valid_reg <= bit_valid_next;
        data_pin_reg  <= data_pin_next;
        latch_reg     <= latch_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign bit_valid   = bit_valid_reg;
    assign data_pin    = data_pin_reg;
    assign latch_pulse = latch_reg;
    assign last        = last_reg;

endmodule

// ----- sv/ssns_div10.sv -----
// Divide-by-ten step: quotient by reciprocal multiply, remainder by subtract
module ssns_div10 (
    input  logic [15:0] dividend,
    output logic [15:0] quotient,
    output logic [3:0]  remainder
);

    localparam logic [15:0] RECIP = 16'd52429;

    logic [31:0] prod;
    logic [15:0] q_times_ten;

    assign prod        = 32'(dividend) * 32'(RECIP);
    assign quotient    = 16'(prod[31:19]);
    assign q_times_ten = 16'(quotient << 3) + 16'(quotient << 1);
    assign remainder   = 4'(dividend - q_times_ten);

endmodule

// ----- sv/ssns_checker.sv -----
// Port-level checker for the number shifter core, bound to the top level
`include "seven_segment_number_shifter_core_macros.svh"

module ssns_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic               bit_valid,
    input logic               data_pin,
    input logic               latch_pulse,
    input logic               last
);

    // an accepted item makes the block busy and raises in_stall
    `SSNS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a latch pulse only ends a request
    `SSNS_ASSERT_SAME(a_latch_is_last, out_valid && latch_pulse, last)

    // a result without a serial tick is a reject or the bare latch, both final
    `SSNS_ASSERT_SAME(a_idle_tick_is_last, out_valid && !bit_valid, last)

    `SSNS_ASSERT_NEXT(a_stalled_hold, out_valid && out_stall,
        out_valid && $stable(data_pin) && $stable(last) && $stable(status))

endmodule

bind seven_segment_number_shifter_core ssns_checker u_ssns_checker (.*);

// ----- dv/tb_seven_segment_number_shifter_core.sv -----
// Self-checking testbench of the seven-segment number shifter core
`timescale 1ns / 100ps

module tb_seven_segment_number_shifter_core;

    localparam int STORE_DIGITS   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 20;

    localparam logic [7:0] DIGIT_SEGMENTS [0:9] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6
    };

    typedef struct {
        ssns_pkg::status_t status;
        logic    bit_valid;
        logic    data_pin;
        logic    latch_pulse;
        logic    last;
    } serial_bit_t;

    class shifter_scoreboard;
        logic [7:0]  segments [STORE_DIGITS];
        logic [3:0]  active_digits;
        serial_bit_t expected_bits [$];
        int          errors;

        function new();
            foreach (segments[k])
                segments[k] = ssns_pkg::SEG_BLANK;
            active_digits = 4'd8;
            errors = 0;
        endfunction

        function void set_active_digits(logic [3:0] value);
            active_digits = value;
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction

        // Saturate at the store size and at eight digits
        function int shifted_digits();
            int n;
            n = active_digits;
            if (n > STORE_DIGITS)
                n = STORE_DIGITS;
            if (n > 8)
                n = 8;
            return n;
        endfunction

        function void queue_shift();
            int  n;
            logic seg_bit;
            logic fin;
            n = shifted_digits();
            if (n == 0)
            begin
                expected_bits.push_back('{ssns_pkg::STATUS_OK, 1'b0, 1'b0, 1'b1, 1'b1});
                return;
            end
            for (int i = 0; i < n * 8; i++)
            begin
                seg_bit = segments[i / 8][i % 8];
                fin = (i == n * 8 - 1);
                expected_bits.push_back('{ssns_pkg::STATUS_OK, 1'b1, ~seg_bit, fin, fin});
            end
        endfunction

        function void push_reject(ssns_pkg::status_t code);
            expected_bits.push_back('{code, 1'b0, 1'b0, 1'b0, 1'b1});
        endfunction

        function void note_request(logic req, logic [7:0] offset, logic [7:0] length,
                                   logic signed [15:0] value);
            int first;
            int span;
            int slot;
            int fill_end;
            int magnitude;
            bit negative;
            bit overflow;
            first = offset;
            span = length;
            if (req == ssns_pkg::REQ_CLEAR)
            begin
                for (int k = 0; k < shifted_digits(); k++)
                    segments[k] = ssns_pkg::SEG_BLANK;
                queue_shift();
                return;
            end
            if (first > STORE_DIGITS)
            begin
                push_reject(ssns_pkg::STATUS_OFFSET);
                return;
            end
            if (first + span > STORE_DIGITS)
            begin
                push_reject(ssns_pkg::STATUS_FIELD_END);
                return;
            end
            negative = value[15];
            magnitude = negative ? -int'(value) : int'(value);
            fill_end = first + span;
            slot = first;
            overflow = 1'b0;
            for (int k = 0; k < span; k++)
                segments[first + k] = ssns_pkg::SEG_BLANK;
            // Least significant digit first
            while (magnitude > 0 && !overflow)
            begin
                if (slot >= fill_end)
                    overflow = 1'b1;
                else
                begin
                    segments[slot] = DIGIT_SEGMENTS[magnitude % 10];
                    magnitude = magnitude / 10;
                    slot++;
                end
            end
            if (negative && slot >= fill_end)
                overflow = 1'b1;
            if (overflow)
            begin
                for (int k = 0; k < span; k++)
                    segments[first + k] = ssns_pkg::SEG_E;
            end
            else if (negative)
                segments[slot] = ssns_pkg::SEG_DASH;
            queue_shift();
        endfunction

        function void report_field(string name, logic [1:0] exp_v, logic [1:0] act_v);
            if (act_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_bit(logic [1:0] st, logic bv, logic dp, logic lp, logic ls);
            serial_bit_t want;
            if (expected_bits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0d bit %b/%b/%b/%b",
                         $time, st, bv, dp, lp, ls);
                return;
            end
            want = expected_bits.pop_front();
            report_field("status", want.status, st);
            report_field("bit_valid", {1'b0, want.bit_valid}, {1'b0, bv});
            report_field("data_pin", {1'b0, want.data_pin}, {1'b0, dp});
            report_field("latch_pulse", {1'b0, want.latch_pulse}, {1'b0, lp});
            report_field("last", {1'b0, want.last}, {1'b0, ls});
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic [7:0]         field_offset;
    logic [7:0]         field_length;
    logic signed [15:0] number_value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic               bit_valid;
    logic               data_pin;
    logic               latch_pulse;
    logic               last;

    shifter_scoreboard sb = new();

    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    seven_segment_number_shifter_core #(
        .STORE_DIGITS(STORE_DIGITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .field_offset (field_offset),
        .field_length (field_length),
        .number_value (number_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .bit_valid    (bit_valid),
        .data_pin     (data_pin),
        .latch_pulse  (latch_pulse),
        .last         (last)
    );

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 4'd0;
        in_valid     = 1'b0;
        req_type     = ssns_pkg::REQ_DISPLAY;
        field_offset = 8'd0;
        field_length = 8'd0;
        number_value = 16'sd0;
        out_stall    = 1'b0;
    end

    always #6 clk = ~clk;

    // Serial output side: check each accepted bit, stall at random or on request
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && !out_stall)
            sb.check_bit(status, bit_valid, data_pin, latch_pulse, last);
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= stall_on && ($urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_active_digits(input logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_active_digits(value);
    endtask

    // Leaves valid high on return so back-to-back items need no extra edge
    task automatic send_item(input logic req, input logic [7:0] offset,
                             input logic [7:0] length, input logic [15:0] value);
        while (gaps_on && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        field_offset <= offset;
        field_length <= length;
        number_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req, offset, length, value);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] random_value();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'($urandom_range(9));
            2: return 16'($urandom_range(999));
            3: return 16'(-int'($urandom_range(9999)));
            4: return 16'($urandom);
            default:
            begin
                case ($urandom_range(2))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    default: return 16'hffff;
                endcase
            end
        endcase
    endfunction

    // Mostly well-formed fields; some clears and some out-of-range noise
    task automatic send_random_items(input int count);
        int roll;
        int offset;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                send_item(ssns_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
            else if (roll < 20)
                send_item(ssns_pkg::REQ_DISPLAY, 8'($urandom), 8'($urandom), random_value());
            else
            begin
                offset = $urandom_range(STORE_DIGITS);
                send_item(ssns_pkg::REQ_DISPLAY, 8'(offset),
                          8'($urandom_range(STORE_DIGITS - offset)), random_value());
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_active_digits(4'd8);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd8, 16'd0);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd5, 16'h7fff);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd4, 16'h7fff);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd6, 16'h8000);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd5, 16'h8000);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd3, 8'd2, 16'hffff);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd7, 8'd1, 16'hffff);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd7, 8'd1, 16'd1);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd8, 8'd0, 16'd5);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd8, 8'd0, 16'd0);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd9, 8'd0, 16'd7);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd255, 8'd255, 16'h5a5a);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd9, 16'd3);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd7, 8'd255, 16'd3);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd1, 8'd255, 16'd3);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd2, 8'd5, 16'd12345);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd6, 8'd2, 16'hfff7);
        send_item(ssns_pkg::REQ_CLEAR, 8'd255, 8'd255, 16'hffff);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd3, 16'd908);
        drain();

        // No active digits: only the bare latch goes out
        write_active_digits(4'd0);
        send_item(ssns_pkg::REQ_DISPLAY, 8'd0, 8'd1, 16'd5);
        send_item(ssns_pkg::REQ_CLEAR, 8'd0, 8'd0, 16'd0);
        drain();

        write_active_digits(4'd15);
        send_random_items(15);
        drain();

        // Hold the output long enough for the core to back up onto its input
        write_active_digits(4'd1);
        send_random_items(10);
        hold_requests <= hold_requests + 1;
        send_random_items(6);
        drain();

        gaps_on  = 1'b0;
        stall_on = 1'b0;
        write_active_digits(4'd8);
        send_random_items(25);
        drain();
        gaps_on  = 1'b1;
        stall_on = 1'b1;

        write_active_digits(4'($urandom_range(15)));
        send_random_items(15);
        drain();

        write_active_digits(4'd3);
        send_random_items(15);
        drain();

        write_active_digits(4'd8);
        send_random_items(15);
        drain();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ssns_pkg.sv
sv/ssns_div10.sv
sv/seven_segment_number_shifter_core.sv
sv/ssns_checker.sv
dv/tb_seven_segment_number_shifter_core.sv
